// File: rtl/json_string_unescape_utf8_core_defines.svh
// Assertion macros shared by the JSON string unescaper modules.
// Depends on clk and rst_n being present in the module that uses a macro.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("jsu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jsu: next-cycle check failed");

`endif

// File: rtl/jsu_pkg.sv
// Shared types, constants and helper functions of the JSON string unescaper.
// No dependencies; the top level, front, queue, back and testbench import this package.
package jsu_pkg;

    // Width of the internal saturating length counter.
    localparam int LENGTH_BITS = 16;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    // Character codes that steer the decoder.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Surrogate and encoding range limits.
    localparam logic [15:0] SUR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SUR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SUR_LO_FIRST = 16'hDC00;
    localparam logic [15:0] SUR_LO_LAST  = 16'hDFFF;
    localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    // Decoder modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX1,
        MODE_WANT_BS,
        MODE_WANT_U,
        MODE_HEX2
    } mode_t;

    // Result kinds as they appear on the output.
    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_DONE    = 3'd1,
        KIND_BADHEX  = 3'd2,
        KIND_BADSUR  = 3'd3,
        KIND_BADESC  = 3'd4,
        KIND_CTRL    = 3'd5,
        KIND_NOQUOTE = 3'd6
    } kind_t;

    // One queued command: a code point to encode, or a single status result.
    typedef struct packed {
        kind_t                  kind;
        logic [20:0]            code;
        logic [1:0]             last_idx;   // number of UTF-8 bytes minus one
        logic [LENGTH_BITS-1:0] len_base;   // length before this command
    } cmd_t;

    // Saturating length add.
    function automatic logic [LENGTH_BITS-1:0] len_add(
        input logic [LENGTH_BITS-1:0] base,
        input logic [2:0]             inc
    );
        logic [LENGTH_BITS:0] sum;
        sum = {1'b0, base} + (LENGTH_BITS + 1)'(inc);
        return sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
    endfunction

    // Hex digit decode: bit 4 flags a valid digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            res = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66) begin
            res = {1'b1, 4'(ch - 8'h57)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46) begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

    // Simple escape decode: bit 8 flags a known single-byte escape.
    function automatic logic [8:0] escape_decode(input logic [7:0] ch);
        logic [8:0] res;
        unique case (ch)
            CH_BACKSLASH, CH_QUOTE, CH_SLASH: res = {1'b1, ch};
            CH_LOWER_B: res = {1'b1, 8'h08};
            CH_LOWER_F: res = {1'b1, 8'h0C};
            CH_LOWER_N: res = {1'b1, 8'h0A};
            CH_LOWER_R: res = {1'b1, 8'h0D};
            CH_LOWER_T: res = {1'b1, 8'h09};
            default:    res = 9'd0;
        endcase
        return res;
    endfunction

    // Byte idx of the UTF-8 form of code point u, which has last_idx+1 bytes.
    function automatic logic [7:0] utf8_byte(
        input logic [20:0] u,
        input logic [1:0]  last_idx,
        input logic [1:0]  idx
    );
        logic [7:0] res;
        res = 8'd0;
        unique case (last_idx)
            2'd0: res = u[7:0];
            2'd1: res = (idx == 2'd0) ? {3'b110, u[10:6]} : {2'b10, u[5:0]};
            2'd2: begin
                unique case (idx)
                    2'd0:    res = {4'b1110, u[15:12]};
                    2'd1:    res = {2'b10, u[11:6]};
                    default: res = {2'b10, u[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    res = {5'b11110, u[20:18]};
                    2'd1:    res = {2'b10, u[17:12]};
                    2'd2:    res = {2'b10, u[11:6]};
                    default: res = {2'b10, u[5:0]};
                endcase
            end
        endcase
        return res;
    endfunction

endpackage

// File: rtl/jsu_if.sv
// Valid/ready channel interfaces for the JSON string unescaper.
// No dependencies.
interface jsu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface jsu_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  kind;
    logic [15:0] decoded_length;
    logic        last;

    modport source (output valid, output out_byte, output kind, output decoded_length,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input decoded_length,
                    input last, output ready);
endinterface

// File: rtl/json_string_unescape_utf8_core.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_cmd_fifo and jsu_back.
//
//   Port      Direction  Carries
//   chars     sink       one raw byte of JSON text per request
//   results   source     one output byte or status (done / error) per request
//
// The front takes one input byte per cycle while the command queue has room.
// A command expands to one to four results at one result per cycle while the
// receiver is ready, set by the single registered output stage; a four-byte
// character needs twelve inputs; results pass the queue, then the output stage.
// Reset clears the decoder mode, counters and queue; no clearing pass is needed.
// A stalled output fills the four-entry queue, after which input is held off.
module json_string_unescape_utf8_core (
    input  logic           clk,
    input  logic           rst_n,
    jsu_byte_if.sink       chars,
    jsu_result_if.source   results
);
    import jsu_pkg::*;

    logic  cmd_push;
    cmd_t  push_cmd;
    logic  cmd_full;
    logic  cmd_pop;
    logic  cmd_valid;
    cmd_t  head_cmd;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (push_cmd)
    );

    jsu_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .head      (head_cmd)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .results   (results)
    );

endmodule

// File: rtl/jsu_front.sv
// Front part: accepts input bytes, tracks the string and escape state and
// queues commands for the back part. Depends on jsu_pkg and jsu_if.
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    jsu_byte_if.sink        chars,
    input  logic            cmd_full,
    output logic            cmd_push,
    output jsu_pkg::cmd_t   cmd
);
    import jsu_pkg::*;

    mode_t                  mode_reg, mode_next;
    logic [1:0]             hex_count_reg, hex_count_next;
    logic [15:0]            acc_reg, acc_next;
    logic [15:0]            high_sur_reg, high_sur_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    logic        accept;
    logic [7:0]  ch;
    logic [4:0]  hex_res;
    logic [8:0]  esc_res;
    logic [15:0] acc_new;
    logic        digit_done;
    logic        acc_is_lo;
    logic        acc_is_hi;
    logic [20:0] pair_code;

    // The queue always has room for the command of an accepted byte.
    assign chars.ready = !cmd_full;
    assign accept      = chars.valid && chars.ready;
    assign ch          = chars.char_byte;

    // Shared decode of the incoming byte.
    assign hex_res    = hex_decode(ch);
    assign esc_res    = escape_decode(ch);
    assign acc_new    = {acc_reg[11:0], hex_res[3:0]};
    assign digit_done = (hex_count_reg == 2'd3);
    assign acc_is_lo  = (acc_new >= SUR_LO_FIRST) && (acc_new <= SUR_LO_LAST);
    assign acc_is_hi  = (acc_new >= SUR_HI_FIRST) && (acc_new <= SUR_HI_LAST);
    assign pair_code  = {1'b0, high_sur_reg[9:0], acc_new[9:0]} + SUPPLEMENTARY_BASE;

    // Next mode, taken only when a byte is accepted.
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (ch == CH_QUOTE) mode_next = MODE_BODY;
            end
            MODE_BODY: begin
                if (ch == CH_QUOTE)          mode_next = MODE_IDLE;
                else if (ch == CH_BACKSLASH) mode_next = MODE_ESC;
                else if (ch < CH_SPACE)      mode_next = MODE_IDLE;
            end
            MODE_ESC: begin
                if (ch == CH_LOWER_U) mode_next = MODE_HEX1;
                else if (esc_res[8])  mode_next = MODE_BODY;
                else                  mode_next = MODE_IDLE;
            end
            MODE_WANT_BS: begin
                mode_next = (ch == CH_BACKSLASH) ? MODE_WANT_U : MODE_IDLE;
            end
            MODE_WANT_U: begin
                mode_next = (ch == CH_LOWER_U) ? MODE_HEX2 : MODE_IDLE;
            end
            MODE_HEX1: begin
                if (!hex_res[4])     mode_next = MODE_IDLE;
                else if (!digit_done) mode_next = MODE_HEX1;
                else if (acc_is_lo)  mode_next = MODE_IDLE;
                else if (acc_is_hi)  mode_next = MODE_WANT_BS;
                else                 mode_next = MODE_BODY;
            end
            MODE_HEX2: begin
                if (!hex_res[4])      mode_next = MODE_IDLE;
                else if (!digit_done) mode_next = MODE_HEX2;
                else if (!acc_is_lo)  mode_next = MODE_IDLE;
                else                  mode_next = MODE_BODY;
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // Commands and datapath updates for the accepted byte.
    always_comb
    begin
        cmd_push       = 1'b0;
        cmd.kind       = KIND_DATA;
        cmd.code       = {13'd0, ch};
        cmd.last_idx   = 2'd0;
        cmd.len_base   = len_reg;
        hex_count_next = hex_count_reg;
        acc_next       = acc_reg;
        high_sur_next  = high_sur_reg;
        len_next       = len_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (ch == CH_QUOTE) len_next = '0;
            end
            MODE_BODY: begin
                if (ch == CH_QUOTE) begin
                    cmd_push = 1'b1;
                    cmd.kind = KIND_DONE;
                end
                else if (ch == CH_BACKSLASH) begin
                    cmd_push = 1'b0;
                end
                else if (ch < CH_SPACE) begin
                    cmd_push       = 1'b1;
                    cmd.kind       = (ch == CH_NUL) ? KIND_NOQUOTE : KIND_CTRL;
                    hex_count_next = 2'd0;
                    acc_next       = 16'd0;
                end
                else begin
                    cmd_push = 1'b1;
                    len_next = len_add(len_reg, 3'd1);
                end
            end
            MODE_ESC: begin
                if (ch == CH_LOWER_U) begin
                    hex_count_next = 2'd0;
                    acc_next       = 16'd0;
                end
                else if (esc_res[8]) begin
                    cmd_push = 1'b1;
                    cmd.code = {13'd0, esc_res[7:0]};
                    len_next = len_add(len_reg, 3'd1);
                end
                else begin
                    cmd_push       = 1'b1;
                    cmd.kind       = KIND_BADESC;
                    hex_count_next = 2'd0;
                    acc_next       = 16'd0;
                end
            end
            MODE_WANT_BS: begin
                if (ch != CH_BACKSLASH) begin
                    cmd_push       = 1'b1;
                    cmd.kind       = KIND_BADSUR;
                    hex_count_next = 2'd0;
                    acc_next       = 16'd0;
                end
            end
            MODE_WANT_U: begin
                cmd_push       = (ch != CH_LOWER_U);
                cmd.kind       = KIND_BADSUR;
                hex_count_next = 2'd0;
                acc_next       = 16'd0;
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hex_res[4]) begin
                    cmd_push       = 1'b1;
                    cmd.kind       = KIND_BADHEX;
                    hex_count_next = 2'd0;
                    acc_next       = 16'd0;
                end
                else if (!digit_done) begin
                    hex_count_next = hex_count_reg + 2'd1;
                    acc_next       = acc_new;
                end
                else begin
                    hex_count_next = 2'd0;
                    acc_next       = 16'd0;
                    if (mode_reg == MODE_HEX1) begin
                        if (acc_is_lo) begin
                            cmd_push = 1'b1;
                            cmd.kind = KIND_BADSUR;
                        end
                        else if (acc_is_hi) begin
                            // Hold the high half until the low escape arrives.
                            high_sur_next = acc_new;
                            acc_next      = acc_new;
                        end
                        else begin
                            cmd_push = 1'b1;
                            cmd.code = {5'd0, acc_new};
                            if (acc_new <= ONE_BYTE_MAX) begin
                                cmd.last_idx = 2'd0;
                                len_next     = len_add(len_reg, 3'd1);
                            end
                            else if (acc_new <= TWO_BYTE_MAX) begin
                                cmd.last_idx = 2'd1;
                                len_next     = len_add(len_reg, 3'd2);
                            end
                            else begin
                                cmd.last_idx = 2'd2;
                                len_next     = len_add(len_reg, 3'd3);
                            end
                        end
                    end
                    else if (!acc_is_lo) begin
                        cmd_push = 1'b1;
                        cmd.kind = KIND_BADSUR;
                    end
                    else begin
                        cmd_push     = 1'b1;
                        cmd.code     = pair_code;
                        cmd.last_idx = 2'd3;
                        len_next     = len_add(len_reg, 3'd4);
                    end
                end
            end
            default: cmd_push = 1'b0;
        endcase
        cmd_push = cmd_push && accept;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_IDLE;
            hex_count_reg <= 2'd0;
            acc_reg       <= 16'd0;
            high_sur_reg  <= 16'd0;
            len_reg       <= '0;
        end
        else if (accept) begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            acc_reg       <= acc_next;
            high_sur_reg  <= high_sur_next;
            len_reg       <= len_next;
        end
    end

endmodule

// File: rtl/jsu_cmd_fifo.sv
// Short command queue between the front and back parts of the unescaper.
// Depends on jsu_pkg and the assertion macro header.
module jsu_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output jsu_pkg::cmd_t   head
);
    import jsu_pkg::*;
    `include "json_string_unescape_utf8_core_defines.svh"

    cmd_t                 entries [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    // Pointer wrap works for any depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end

    // Queue storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (push) entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `JSU_ASSERT_SAME(a_no_push_when_full, push, !full)
    `JSU_ASSERT_SAME(a_no_pop_when_empty, pop, not_empty)
    `JSU_ASSERT_NEXT(a_count_tracks, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// File: rtl/jsu_back.sv
// Back part: expands queued commands into UTF-8 bytes and status results
// through a registered output stage. Depends on jsu_pkg, jsu_if and the macros.
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  jsu_pkg::cmd_t   cmd,
    output logic            cmd_pop,
    jsu_result_if.source    results
);
    import jsu_pkg::*;
    `include "json_string_unescape_utf8_core_defines.svh"

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    kind_t       kind_reg;
    logic [15:0] len_reg;
    logic        last_reg;

    logic                   load;
    logic                   at_last;
    logic                   is_data;
    logic [LENGTH_BITS-1:0] len_now;

    // The output register takes a new result whenever it is empty or drained.
    assign load    = cmd_valid && (!out_valid_reg || results.ready);
    assign at_last = (idx_reg == cmd.last_idx);
    assign is_data = (cmd.kind == KIND_DATA);
    assign cmd_pop = load && at_last;
    assign len_now = is_data ? len_add(cmd.len_base, {1'b0, idx_reg} + 3'd1) : cmd.len_base;

    always_comb
    begin
        idx_next = idx_reg;
        if (load) idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
    end

    // Control: byte index within the command and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg <= idx_next;
            if (load)               out_valid_reg <= 1'b1;
            else if (results.ready) out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg <= is_data ? utf8_byte(cmd.code, cmd.last_idx, idx_reg) : 8'd0;
            kind_reg     <= cmd.kind;
            len_reg      <= 16'(len_now);
            last_reg     <= at_last;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.out_byte       = out_byte_reg;
    assign results.kind           = kind_reg;
    assign results.decoded_length = len_reg;
    assign results.last           = last_reg;

    `JSU_ASSERT_SAME(a_status_is_single,
                     out_valid_reg && (kind_reg != KIND_DATA), last_reg && (out_byte_reg == 8'd0))
    `JSU_ASSERT_SAME(a_partial_cmd_present, idx_reg != 2'd0, cmd_valid)
    `JSU_ASSERT_SAME(a_status_one_byte, cmd_valid && !is_data, cmd.last_idx == 2'd0)

endmodule

// File: verif/json_string_unescape_utf8_core_tb.sv
// Self-checking testbench for the streaming JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_if and json_string_unescape_utf8_core. It predicts results
// from the requests it sends unless a row types them, and checks directed and random traffic.
module json_string_unescape_utf8_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0]  data;
        kind_t       kind;
        logic [15:0] len;
        logic        last;
    } result_t;

    // One input request, optionally with a result written out by hand.
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } request_t;

    // Row of the directed table; typed rows cause exactly one result.
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic [7:0]  data;
        kind_t       kind;
        logic [15:0] len;
    } text_row_t;

    localparam int TEXT_ROWS = 66;
    localparam text_row_t DIRECTED_TEXT [0:TEXT_ROWS-1] = '{
        // Ignored while idle, then a string with extremes, escapes and a pair.
        '{"x",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{8'hFF,        1'b1, 8'hFF, KIND_DATA,    16'd1},
        '{CH_SPACE,     1'b1, 8'h20, KIND_DATA,    16'd2},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_N,   1'b1, 8'h0A, KIND_DATA,    16'd3},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"2",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"A",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"c",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"D",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"8",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"3",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"d",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"D",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"E",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_QUOTE,     1'b1, 8'h00, KIND_DONE,    16'd10},
        // Zero byte in the body.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_NUL,       1'b1, 8'h00, KIND_NOQUOTE, 16'd0},
        // Control byte in the body.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"A",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{8'h1F,        1'b1, 8'h00, KIND_CTRL,    16'd1},
        // Zero byte as an escape letter.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_NUL,       1'b1, 8'h00, KIND_BADESC,  16'd0},
        // Non-hex byte inside a code point escape.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"f",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"G",          1'b1, 8'h00, KIND_BADHEX,  16'd0},
        // Low surrogate with no high surrogate before it.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"D",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"C",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b1, 8'h00, KIND_BADSUR,  16'd0},
        // High surrogate followed by something other than a backslash.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"D",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"B",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"F",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"F",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"x",          1'b1, 8'h00, KIND_BADSUR,  16'd0},
        // High surrogate followed by an escape outside the low range.
        '{CH_QUOTE,     1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"D",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"8",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_BACKSLASH, 1'b0, 8'h00, KIND_DATA,    16'd0},
        '{CH_LOWER_U,   1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"0",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"4",          1'b0, 8'h00, KIND_DATA,    16'd0},
        '{"1",          1'b1, 8'h00, KIND_BADSUR,  16'd0}
    };

    localparam logic [7:0] ESC_LETTERS [0:7] = '{
        CH_BACKSLASH, CH_QUOTE, CH_SLASH, CH_LOWER_B,
        CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T
    };

    localparam int PHASE_ITEMS = 85;

    logic clk;
    logic rst_n;

    jsu_byte_if   chars_if ();
    jsu_result_if res_if ();

    json_string_unescape_utf8_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if)
    );

    // Traffic state shared by the main sequence and the channel processes.
    request_t text_bytes [$];
    result_t  expected_results [$];
    result_t  step_results [$];
    request_t current_request;
    result_t  oldest;
    int       bytes_pending;
    int       random_items;
    int       mismatches;
    int       sender_idle_pct;
    int       receiver_stall_pct;
    logic     hold_on;

    // Decoder state as predicted from the accepted requests.
    mode_t                  pred_mode;
    logic [1:0]             pred_digits;
    logic [15:0]            pred_code;
    logic [15:0]            pred_high;
    logic [LENGTH_BITS-1:0] pred_len;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    task report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    task push_data(input logic [7:0] b);
        if (pred_len != '1)
            pred_len = pred_len + 1'b1;
        step_results.push_back('{b, KIND_DATA, 16'(pred_len), 1'b0});
    endtask

    task push_status(input kind_t k);
        step_results.push_back('{8'h00, k, 16'(pred_len), 1'b0});
    endtask

    // An error result sends the decoder back to idle.
    task abort_with(input kind_t k);
        push_status(k);
        pred_mode   = MODE_IDLE;
        pred_digits = 2'd0;
        pred_code   = 16'd0;
    endtask

    // UTF-8 form of one code point, one to four bytes.
    task encode_point(input logic [20:0] u);
        if (u <= 21'h7F)
        begin
            push_data(u[7:0]);
        end
        else if (u <= 21'h7FF)
        begin
            push_data({3'b110, u[10:6]});
            push_data({2'b10, u[5:0]});
        end
        else if (u <= 21'hFFFF)
        begin
            push_data({4'b1110, u[15:12]});
            push_data({2'b10, u[11:6]});
            push_data({2'b10, u[5:0]});
        end
        else
        begin
            push_data({5'b11110, u[20:18]});
            push_data({2'b10, u[17:12]});
            push_data({2'b10, u[11:6]});
            push_data({2'b10, u[5:0]});
        end
    endtask

    // Predicts the results of one accepted byte into step_results.
    task unescape_step(input logic [7:0] c);
        int          h;
        logic [20:0] u;
        step_results.delete();
        case (pred_mode)
            MODE_IDLE:
            begin
                if (c == CH_QUOTE)
                begin
                    pred_mode = MODE_BODY;
                    pred_len  = '0;
                end
            end
            MODE_BODY:
            begin
                if (c == CH_QUOTE)
                begin
                    pred_mode = MODE_IDLE;
                    push_status(KIND_DONE);
                end
                else if (c == CH_BACKSLASH)
                    pred_mode = MODE_ESC;
                else if (c == CH_NUL)
                    abort_with(KIND_NOQUOTE);
                else if (c < CH_SPACE)
                    abort_with(KIND_CTRL);
                else
                    push_data(c);
            end
            MODE_ESC:
            begin
                pred_mode = MODE_BODY;
                case (c)
                    CH_BACKSLASH, CH_QUOTE, CH_SLASH: push_data(c);
                    CH_LOWER_B: push_data(8'h08);
                    CH_LOWER_F: push_data(8'h0C);
                    CH_LOWER_N: push_data(8'h0A);
                    CH_LOWER_R: push_data(8'h0D);
                    CH_LOWER_T: push_data(8'h09);
                    CH_LOWER_U:
                    begin
                        pred_mode   = MODE_HEX1;
                        pred_digits = 2'd0;
                        pred_code   = 16'd0;
                    end
                    default: abort_with(KIND_BADESC);
                endcase
            end
            MODE_WANT_BS:
            begin
                if (c != CH_BACKSLASH)
                    abort_with(KIND_BADSUR);
                else
                    pred_mode = MODE_WANT_U;
            end
            MODE_WANT_U:
            begin
                if (c != CH_LOWER_U)
                    abort_with(KIND_BADSUR);
                else
                begin
                    pred_mode   = MODE_HEX2;
                    pred_digits = 2'd0;
                    pred_code   = 16'd0;
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                h = hex_value(c);
                if (h < 0)
                    abort_with(KIND_BADHEX);
                else
                begin
                    pred_code = {pred_code[11:0], 4'(h)};
                    if (pred_digits != 2'd3)
                        pred_digits = pred_digits + 2'd1;
                    else
                    begin
                        pred_digits = 2'd0;
                        if (pred_mode == MODE_HEX1)
                        begin
                            // First escape: a low surrogate is an error, a high one waits.
                            if (pred_code >= SUR_LO_FIRST && pred_code <= SUR_LO_LAST)
                                abort_with(KIND_BADSUR);
                            else if (pred_code >= SUR_HI_FIRST && pred_code <= SUR_HI_LAST)
                            begin
                                pred_high = pred_code;
                                pred_mode = MODE_WANT_BS;
                            end
                            else
                            begin
                                u         = {5'd0, pred_code};
                                pred_mode = MODE_BODY;
                                pred_code = 16'd0;
                                encode_point(u);
                            end
                        end
                        else if (pred_code < SUR_LO_FIRST || pred_code > SUR_LO_LAST)
                            abort_with(KIND_BADSUR);
                        else
                        begin
                            // Combine the pair into a supplementary code point.
                            u = {1'b0, 10'(pred_high - SUR_HI_FIRST),
                                 10'(pred_code - SUR_LO_FIRST)} + 21'h10000;
                            pred_mode = MODE_BODY;
                            pred_code = 16'd0;
                            encode_point(u);
                        end
                    end
                end
            end
            default: pred_mode = MODE_IDLE;
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // Sender: offers queued requests, idling at random between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid     <= 1'b0;
            chars_if.char_byte <= 8'h00;
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                unescape_step(current_request.ch);
                if (current_request.typed)
                    expected_results.push_back(current_request.want);
                else
                    foreach (step_results[k])
                        expected_results.push_back(step_results[k]);
                bytes_pending--;
            end
            if (!chars_if.valid || chars_if.ready)
            begin
                if (text_bytes.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    current_request = text_bytes.pop_front();
                    chars_if.valid     <= 1'b1;
                    chars_if.char_byte <= current_request.ch;
                end
                else
                    chars_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h len %0d",
                                              res_if.kind, res_if.out_byte,
                                              res_if.decoded_length));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (res_if.out_byte !== oldest.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  res_if.out_byte, oldest.data));
                    if (res_if.kind !== oldest.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  res_if.kind, oldest.kind));
                    if (res_if.decoded_length !== oldest.len)
                        report_mismatch($sformatf("decoded_length %0d, expected %0d",
                                                  res_if.decoded_length, oldest.len));
                    if (res_if.last !== oldest.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  res_if.last, oldest.last));
                end
            end
            res_if.ready <= !hold_on && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Long receiver hold-off so the command queue fills and input stalls.
    task hold_results(input int cycles);
        hold_on <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_on <= 1'b0;
    endtask

    task push_text(input logic [7:0] c, input bit counted);
        request_t r;
        r    = '0;
        r.ch = c;
        text_bytes.push_back(r);
        bytes_pending++;
        if (counted)
            random_items++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
            return 8'h30 + 8'(d);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 255));
        while (c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    // A code point below 0x10000 that is not a surrogate, spread over the UTF-8 lengths.
    function automatic logic [15:0] bmp_point();
        logic [15:0] v;
        case ($urandom_range(2))
            0:       v = 16'($urandom_range(0, 16'h7F));
            1:       v = 16'($urandom_range(16'h80, 16'h7FF));
            default:
            begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= SUR_HI_FIRST && v <= SUR_LO_LAST)
                    v = v ^ 16'h4000;
            end
        endcase
        return v;
    endfunction

    task push_u_escape(input logic [15:0] v);
        push_text(CH_BACKSLASH, 1'b1);
        push_text(CH_LOWER_U, 1'b1);
        for (int i = 3; i >= 0; i--)
            push_text(hex_char(v[i*4 +: 4]), 1'b1);
    endtask

    // One piece of string content; with errors allowed, some pieces are malformed.
    task push_piece(input bit allow_err);
        int          pick;
        int          good;
        logic [7:0]  c;
        logic [15:0] high;
        pick = $urandom_range(99);
        high = SUR_HI_FIRST + 16'($urandom_range(16'h3FF));
        if (pick < 40 || (pick >= 85 && !allow_err))
            push_text(plain_char(), 1'b1);
        else if (pick < 55)
        begin
            push_text(CH_BACKSLASH, 1'b1);
            push_text(ESC_LETTERS[$urandom_range(7)], 1'b1);
        end
        else if (pick < 72)
            push_u_escape(bmp_point());
        else if (pick < 85)
        begin
            push_u_escape(high);
            push_u_escape(SUR_LO_FIRST + 16'($urandom_range(16'h3FF)));
        end
        else
        begin
            case ($urandom_range(7))
                0: push_text(8'($urandom_range(1, 31)), 1'b1);
                1: push_text(CH_NUL, 1'b1);
                2:
                begin
                    push_text(CH_BACKSLASH, 1'b1);
                    push_text(8'($urandom_range(255)), 1'b1);
                end
                3:
                begin
                    push_text(CH_BACKSLASH, 1'b1);
                    push_text(CH_LOWER_U, 1'b1);
                    good = $urandom_range(3);
                    repeat (good)
                        push_text(hex_char(4'($urandom_range(15))), 1'b1);
                    do
                        c = 8'($urandom_range(255));
                    while (hex_value(c) >= 0);
                    push_text(c, 1'b1);
                end
                4: push_u_escape(SUR_LO_FIRST + 16'($urandom_range(16'h3FF)));
                5:
                begin
                    push_u_escape(high);
                    push_text(8'($urandom_range(255)), 1'b1);
                end
                6:
                begin
                    push_u_escape(high);
                    push_text(CH_BACKSLASH, 1'b1);
                    push_text(8'($urandom_range(255)), 1'b1);
                end
                default:
                begin
                    push_u_escape(high);
                    push_u_escape($urandom_range(1) ? bmp_point() : high);
                end
            endcase
        end
    endtask

    // A quoted string with random content, preceded by a little idle noise.
    task push_string();
        bit         broken;
        int         pieces;
        logic [7:0] c;
        broken = ($urandom_range(99) < 20);
        repeat ($urandom_range(2))
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CH_QUOTE);
            push_text(c, 1'b0);
        end
        push_text(CH_QUOTE, 1'b1);
        pieces = $urandom_range(8);
        repeat (pieces)
            push_piece(broken);
        if (!broken || $urandom_range(1))
            push_text(CH_QUOTE, 1'b1);
    endtask

    // Waits until every request is taken and every result has arrived.
    task wait_drained();
        while (bytes_pending != 0 || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task run_random_phase(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        random_items       = 0;
        while (random_items < PHASE_ITEMS)
            push_string();
        wait_drained();
    endtask

    // Main sequence.
    initial
    begin
        request_t r;
        rst_n              = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.char_byte = 8'h00;
        res_if.ready       = 1'b0;
        hold_on            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        bytes_pending      = 0;
        random_items       = 0;
        mismatches         = 0;
        pred_mode          = MODE_IDLE;
        pred_digits        = 2'd0;
        pred_code          = 16'd0;
        pred_high          = 16'd0;
        pred_len           = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed text.
        foreach (DIRECTED_TEXT[i])
        begin
            r       = '0;
            r.ch    = DIRECTED_TEXT[i].ch;
            r.typed = DIRECTED_TEXT[i].typed;
            r.want  = '{DIRECTED_TEXT[i].data, DIRECTED_TEXT[i].kind,
                        DIRECTED_TEXT[i].len, 1'b1};
            text_bytes.push_back(r);
            bytes_pending++;
        end
        wait_drained();

        // Random strings; the first phase starts with a long receiver hold-off.
        fork
            hold_results(80);
        join_none
        run_random_phase(0, 0);
        run_random_phase(72, 0);
        run_random_phase(0, 72);
        run_random_phase(7, 7);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
